/* hw/rtl/rtbp_pkg.sv */
// ----------------------------------------------------------------------------
// rtbp_pkg
// Shared constants and codes for the rgb threshold bitplane packer.
// ----------------------------------------------------------------------------
package rtbp_pkg;

  // image size limits
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  // field widths
  localparam int unsigned ChanW  = 8;   // colour component
  localparam int unsigned SizeW  = 13;  // width and height registers
  localparam int unsigned ThrW   = 8;   // grey threshold
  localparam int unsigned ByteW  = 8;   // packed output byte
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = SizeW;

  // counter widths follow from the limits
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);

  // weighted sum: 30 + 59 + 11 = 100, max 100 * 255 = 25500
  localparam int unsigned SumW  = 15;
  localparam int unsigned WRed   = 30;
  localparam int unsigned WGreen = 59;
  localparam int unsigned WBlue  = 11;
  localparam int unsigned Divisor = 100;

  // bit position within a byte
  localparam int unsigned PosW = $clog2(ByteW);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth    = 2'd0,
    CfgImageHeight   = 2'd1,
    CfgGreyThreshold = 2'd2
  } cfg_reg_e;

  // reset values
  localparam logic [SizeW-1:0] ResetWidth     = 13'd8;
  localparam logic [SizeW-1:0] ResetHeight    = 13'd1;
  localparam logic [ThrW-1:0]  ResetThreshold = 8'd128;

endpackage

/* hw/rtl/rtbp_if.sv */
// ----------------------------------------------------------------------------
// rtbp channel interfaces
// Valid/ready channels for pixels, packed bytes and configuration writes.
// ----------------------------------------------------------------------------

// pixel channel
interface rtbp_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [rtbp_pkg::ChanW-1:0]    red;
  logic [rtbp_pkg::ChanW-1:0]    green;
  logic [rtbp_pkg::ChanW-1:0]    blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// packed byte channel
interface rtbp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [rtbp_pkg::ByteW-1:0]    packed_byte;
  logic                          row_end;
  logic                          image_end;

  modport source (output valid, output packed_byte, output row_end, output image_end,
                  input ready);
  modport sink   (input valid, input packed_byte, input row_end, input image_end,
                  output ready);
endinterface

// configuration write channel
interface rtbp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rtbp_pkg::CfgIdxW-1:0]   index;
  logic [rtbp_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/rtbp_luma_cmp.sv */
// ----------------------------------------------------------------------------
// rtbp_luma_cmp
// Weighted luma sum of one pixel compared against the grey threshold.
// ----------------------------------------------------------------------------
module rtbp_luma_cmp (
  input  logic [rtbp_pkg::ChanW-1:0] red_i,
  input  logic [rtbp_pkg::ChanW-1:0] green_i,
  input  logic [rtbp_pkg::ChanW-1:0] blue_i,
  input  logic [rtbp_pkg::ThrW-1:0]  threshold_i,
  output logic                       dark_o
);

  localparam int unsigned PadW = rtbp_pkg::SumW - rtbp_pkg::ChanW;
  localparam int unsigned ThrPadW = rtbp_pkg::SumW - rtbp_pkg::ThrW;

  logic [rtbp_pkg::SumW-1:0] sum;
  logic [rtbp_pkg::SumW-1:0] limit;

  // 30r + 59g + 11b, at most 25500
  assign sum = {{PadW{1'b0}}, red_i}   * rtbp_pkg::SumW'(rtbp_pkg::WRed)
             + {{PadW{1'b0}}, green_i} * rtbp_pkg::SumW'(rtbp_pkg::WGreen)
             + {{PadW{1'b0}}, blue_i}  * rtbp_pkg::SumW'(rtbp_pkg::WBlue);

  // floor(sum / 100) < thr exactly when sum < 100 * thr
  assign limit = {{ThrPadW{1'b0}}, threshold_i} * rtbp_pkg::SumW'(rtbp_pkg::Divisor);

  assign dark_o = (sum < limit);

endmodule

/* hw/rtl/rgb_threshold_bitplane_packer_unit.sv */
// ----------------------------------------------------------------------------
// rgb_threshold_bitplane_packer_unit
// Thresholds RGB pixels on luma and packs the bits lsb first into bytes.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  pix_i     in   valid / ready    red, green, blue
//  byte_o    out  valid / ready    packed_byte, row_end, image_end
//  cfg_i     in   valid / ready    index, data (always ready)
//
//  one pixel per clock while the output is not stalled: input register, then luma
//  compare and packing into the output register; the request that closes a byte
//  passes the input register and then the output register, which offers it.
//  a stalled output holds the byte; the input register fills behind it, so
//  pixels keep coming until both stages are full.
//  reset clears counters, partial byte, valid flags and loads register defaults.
//
module rgb_threshold_bitplane_packer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rtbp_pixel_if.sink  pix_i,
  rtbp_byte_if.source byte_o,
  rtbp_cfg_if.sink    cfg_i
);

  localparam int unsigned ColPadW = rtbp_pkg::SizeW - rtbp_pkg::ColW;
  localparam int unsigned RowPadW = rtbp_pkg::SizeW - rtbp_pkg::RowW;

  // configuration registers
  logic [rtbp_pkg::SizeW-1:0] width_q;
  logic [rtbp_pkg::SizeW-1:0] height_q;
  logic [rtbp_pkg::ThrW-1:0]  thr_q;

  // input register
  logic                       in_valid_q;
  logic [rtbp_pkg::ChanW-1:0] red_q, green_q, blue_q;

  // packing state
  logic [rtbp_pkg::ColW-1:0]  col_q, col_d;
  logic [rtbp_pkg::RowW-1:0]  row_q, row_d;
  logic [rtbp_pkg::ByteW-1:0] part_q, part_d;

  // output register
  logic                       out_valid_q;
  logic [rtbp_pkg::ByteW-1:0] byte_q;
  logic                       row_end_q;
  logic                       image_end_q;

  logic                       advance;
  logic                       dark;
  logic [rtbp_pkg::SizeW-1:0] width_eff, height_eff;
  logic [rtbp_pkg::PosW-1:0]  pos;
  logic                       last_col, last_row, emit;
  logic [rtbp_pkg::ByteW-1:0] bits;

  // configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rtbp_pkg::ResetWidth;
      height_q <= rtbp_pkg::ResetHeight;
      thr_q    <= rtbp_pkg::ResetThreshold;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rtbp_pkg::CfgImageWidth:    width_q  <= cfg_i.data;
        rtbp_pkg::CfgImageHeight:   height_q <= cfg_i.data;
        rtbp_pkg::CfgGreyThreshold: thr_q    <= cfg_i.data[rtbp_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  assign advance     = in_valid_q && (!out_valid_q || byte_o.ready);
  assign pix_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
    end
  end

  // luma threshold
  rtbp_luma_cmp u_luma (
    .red_i       (red_q),
    .green_i     (green_q),
    .blue_i      (blue_q),
    .threshold_i (thr_q),
    .dark_o      (dark)
  );

  // effective image size: zero reads as one, large values saturate
  always_comb begin
    if (width_q == '0) begin
      width_eff = rtbp_pkg::SizeW'(1);
    end else if (width_q > rtbp_pkg::SizeW'(rtbp_pkg::MaxWidth)) begin
      width_eff = rtbp_pkg::SizeW'(rtbp_pkg::MaxWidth);
    end else begin
      width_eff = width_q;
    end
    if (height_q == '0) begin
      height_eff = rtbp_pkg::SizeW'(1);
    end else if (height_q > rtbp_pkg::SizeW'(rtbp_pkg::MaxHeight)) begin
      height_eff = rtbp_pkg::SizeW'(rtbp_pkg::MaxHeight);
    end else begin
      height_eff = height_q;
    end
  end

  // packing and counter update
  always_comb begin
    pos      = col_q[rtbp_pkg::PosW-1:0];
    last_col = ({{ColPadW{1'b0}}, col_q} + rtbp_pkg::SizeW'(1)) >= width_eff;
    last_row = ({{RowPadW{1'b0}}, row_q} + rtbp_pkg::SizeW'(1)) >= height_eff;
    bits     = part_q | (rtbp_pkg::ByteW'(dark) << pos);
    emit     = (pos == rtbp_pkg::PosW'(rtbp_pkg::ByteW - 1)) || last_col;
    part_d   = emit ? '0 : bits;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + rtbp_pkg::RowW'(1);
    end else begin
      col_d = col_q + rtbp_pkg::ColW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      part_q <= '0;
    end else if (advance) begin
      col_q  <= col_d;
      row_q  <= row_d;
      part_q <= part_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (byte_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      byte_q      <= bits;
      row_end_q   <= last_col;
      image_end_q <= last_col && last_row;
    end
  end

  assign byte_o.valid       = out_valid_q;
  assign byte_o.packed_byte = byte_q;
  assign byte_o.row_end     = row_end_q;
  assign byte_o.image_end   = image_end_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for rgb_threshold_bitplane_packer_unit. Pixels go in through the
// valid/ready pixel channel, and the expected packed bytes are worked out by
// a local luma threshold and packing model as each request is accepted.
// Every byte leaving the block is checked against the oldest expected byte.
// Directed requests cover colour and threshold extremes, size clamping and
// register writes in the middle of an image. Random images follow, under
// several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WatchdogLimit   = 2000;
  localparam int unsigned PipeDrainCycles = 6;
  localparam int unsigned MaxReports      = 10;
  localparam int unsigned ImagesPerPhase  = 4;
  localparam int unsigned PixelsPerImage  = 70;

  // index with no register behind it, written to check that it is ignored
  localparam logic [rtbp_pkg::CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

  typedef struct packed {
    logic [rtbp_pkg::ChanW-1:0] red;
    logic [rtbp_pkg::ChanW-1:0] green;
    logic [rtbp_pkg::ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [rtbp_pkg::ByteW-1:0] packed_byte;
    logic                       row_end;
    logic                       image_end;
  } packed_out_t;

  logic clk;
  logic rst_n;

  rtbp_pixel_if pix_if ();
  rtbp_byte_if  byte_if ();
  rtbp_cfg_if   cfg_if ();

  rgb_threshold_bitplane_packer_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .byte_o (byte_if),
    .cfg_i  (cfg_if)
  );

  // idle pattern of the current phase, in percent
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  // local copy of the registers and packing state
  logic [rtbp_pkg::SizeW-1:0] width_reg;
  logic [rtbp_pkg::SizeW-1:0] height_reg;
  logic [rtbp_pkg::ThrW-1:0]  thr_reg;
  int unsigned                col_count;
  int unsigned                row_count;
  logic [rtbp_pkg::ByteW-1:0] partial_bits;

  packed_out_t pending_bytes[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // zero and oversize dimensions map onto the legal range
  function automatic int unsigned size_limit(input logic [rtbp_pkg::SizeW-1:0] value,
                                             input int unsigned max_size);
    if (value == '0) return 1;
    if (32'(value) > max_size) return max_size;
    return 32'(value);
  endfunction

  // threshold one pixel into the partial byte, queue a byte when one closes
  function automatic void predict_pixel(input rgb_t px);
    int unsigned w;
    int unsigned h;
    int unsigned grey;
    int unsigned pos;
    bit          last_col;
    bit          last_row;
    packed_out_t want;
    w        = size_limit(width_reg, rtbp_pkg::MaxWidth);
    h        = size_limit(height_reg, rtbp_pkg::MaxHeight);
    grey     = (rtbp_pkg::WRed * 32'(px.red) + rtbp_pkg::WGreen * 32'(px.green) +
                rtbp_pkg::WBlue * 32'(px.blue)) / rtbp_pkg::Divisor;
    pos      = col_count % rtbp_pkg::ByteW;
    last_col = (col_count + 1 >= w);
    last_row = (row_count + 1 >= h);
    if (grey < 32'(thr_reg)) partial_bits[pos] = 1'b1;
    if (pos == rtbp_pkg::ByteW - 1 || last_col) begin
      want.packed_byte = partial_bits;
      want.row_end     = last_col;
      want.image_end   = last_col && last_row;
      pending_bytes.push_back(want);
      partial_bits = '0;
    end
    if (last_col) begin
      col_count = 0;
      row_count = last_row ? 0 : row_count + 1;
    end else begin
      col_count = col_count + 1;
    end
  endfunction

  // random pixel: uniform, or a grey close to the current threshold
  function automatic rgb_t rand_pixel();
    rgb_t px;
    int   v;
    if ($urandom_range(3) == 0) begin
      v = int'(thr_reg) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      px.red   = v[7:0];
      px.green = v[7:0];
      px.blue  = v[7:0];
    end else begin
      px.red   = rtbp_pkg::ChanW'($urandom_range(255));
      px.green = rtbp_pkg::ChanW'($urandom_range(255));
      px.blue  = rtbp_pkg::ChanW'($urandom_range(255));
    end
    return px;
  endfunction

  // image width: mostly small, now and then zero, the maximum or above it
  function automatic logic [rtbp_pkg::SizeW-1:0] pick_width();
    case ($urandom_range(19))
      0:       return '0;
      1:       return rtbp_pkg::SizeW'(rtbp_pkg::MaxWidth);
      2:       return rtbp_pkg::SizeW'($urandom_range(rtbp_pkg::MaxWidth + 1,
                                                      (1 << rtbp_pkg::SizeW) - 1));
      3:       return rtbp_pkg::SizeW'($urandom_range(40, 200));
      default: return rtbp_pkg::SizeW'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [rtbp_pkg::SizeW-1:0] pick_height();
    case ($urandom_range(19))
      0:       return '0;
      1:       return rtbp_pkg::SizeW'(rtbp_pkg::MaxHeight);
      2:       return rtbp_pkg::SizeW'($urandom_range(rtbp_pkg::MaxHeight + 1,
                                                      (1 << rtbp_pkg::SizeW) - 1));
      default: return rtbp_pkg::SizeW'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [rtbp_pkg::CfgDataW-1:0] pick_threshold();
    case ($urandom_range(9))
      0:       return '0;
      1:       return rtbp_pkg::CfgDataW'(255);
      default: return rtbp_pkg::CfgDataW'($urandom_range((1 << rtbp_pkg::CfgDataW) - 1));
    endcase
  endfunction

  // one pixel request, with random idle cycles ahead of it
  task automatic send_pixel(input rgb_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= px.red;
    pix_if.green <= px.green;
    pix_if.blue  <= px.blue;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_pixel(px);
  endtask

  // register write, mirrored into the local copy once accepted
  task automatic write_reg(input logic [rtbp_pkg::CfgIdxW-1:0] idx,
                           input logic [rtbp_pkg::CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      rtbp_pkg::CfgImageWidth:    width_reg  = value;
      rtbp_pkg::CfgImageHeight:   height_reg = value;
      rtbp_pkg::CfgGreyThreshold: thr_reg    = value[rtbp_pkg::ThrW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop sending, wait for every expected byte and for the pipeline to empty
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (PipeDrainCycles) @(posedge clk);
  endtask

  // reset register values, one full row of eight with colour extremes
  task automatic test_default_row();
    send_pixel('{8'd0,   8'd0,   8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd128, 8'd128, 8'd128});
    send_pixel('{8'd127, 8'd127, 8'd127});
    send_pixel('{8'd255, 8'd0,   8'd0});
    send_pixel('{8'd0,   8'd255, 8'd0});
    send_pixel('{8'd0,   8'd0,   8'd255});
    send_pixel('{8'd100, 8'd200, 8'd50});
    wait_idle();
  endtask

  // thresholds of zero and full scale, upper data bits set on the first
  task automatic test_threshold_extremes();
    write_reg(rtbp_pkg::CfgImageWidth, 13'd1);
    write_reg(rtbp_pkg::CfgImageHeight, 13'd1);
    write_reg(rtbp_pkg::CfgGreyThreshold, 13'h1f00);
    send_pixel('{8'd0, 8'd0, 8'd0});
    wait_idle();
    write_reg(rtbp_pkg::CfgGreyThreshold, 13'h00ff);
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd255, 8'd254});
    send_pixel('{8'd0,   8'd0,   8'd0});
    wait_idle();
  endtask

  // zero width and height act as one; single column image of three rows
  task automatic test_size_extremes();
    write_reg(rtbp_pkg::CfgImageWidth, 13'd0);
    write_reg(rtbp_pkg::CfgImageHeight, 13'd0);
    write_reg(rtbp_pkg::CfgGreyThreshold, 13'd128);
    send_pixel('{8'd10, 8'd10, 8'd10});
    wait_idle();
    write_reg(rtbp_pkg::CfgImageWidth, 13'd1);
    write_reg(rtbp_pkg::CfgImageHeight, 13'd3);
    send_pixel('{8'd200, 8'd10,  8'd10});
    send_pixel('{8'd10,  8'd200, 8'd10});
    send_pixel('{8'd10,  8'd10,  8'd200});
    wait_idle();
  endtask

  // shrink width and height part way through, poke the unused index
  task automatic test_mid_image_write();
    write_reg(rtbp_pkg::CfgImageWidth, 13'd20);
    write_reg(rtbp_pkg::CfgImageHeight, 13'd2);
    send_pixel('{8'd0,   8'd0,   8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd0,   8'd0,   8'd0});
    wait_idle();
    write_reg(rtbp_pkg::CfgImageWidth, 13'd2);
    send_pixel('{8'd0, 8'd0, 8'd0});
    wait_idle();
    write_reg(CfgUnusedIdx, 13'h1fff);
    send_pixel('{8'd0, 8'd0, 8'd0});
    wait_idle();
    write_reg(rtbp_pkg::CfgImageHeight, 13'd1);
    send_pixel('{8'd0, 8'd0, 8'd0});
    wait_idle();
  endtask

  // random images under one idle pattern, fresh registers for each image
  task automatic test_random_images(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int img = 0; img < ImagesPerPhase; img++) begin
      wait_idle();
      write_reg(rtbp_pkg::CfgImageWidth, pick_width());
      write_reg(rtbp_pkg::CfgImageHeight, pick_height());
      write_reg(rtbp_pkg::CfgGreyThreshold, pick_threshold());
      repeat (PixelsPerImage) send_pixel(rand_pixel());
    end
    wait_idle();
  endtask

  // receiver stalls
  always @(posedge clk) begin
    byte_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // compare each accepted byte with the oldest expectation
  always @(posedge clk) begin : check_bytes
    packed_out_t got;
    packed_out_t want;
    if (rst_n && byte_if.valid && byte_if.ready) begin
      got = {byte_if.packed_byte, byte_if.row_end, byte_if.image_end};
      if (pending_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: byte %02h row_end %0b image_end %0b with no request outstanding",
                   $time, got.packed_byte, got.row_end, got.image_end);
      end else begin
        want = pending_bytes.pop_front();
        if (got.packed_byte !== want.packed_byte || got.row_end !== want.row_end ||
            got.image_end !== want.image_end) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: expected byte %02h row_end %0b image_end %0b, got %02h %0b %0b",
                     $time, want.packed_byte, want.row_end, want.image_end,
                     got.packed_byte, got.row_end, got.image_end);
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_if.valid && pix_if.ready) || (byte_if.valid && byte_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // test sequence
  initial begin
    pix_if.valid   = 1'b0;
    pix_if.red     = '0;
    pix_if.green   = '0;
    pix_if.blue    = '0;
    byte_if.ready  = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = rtbp_pkg::CfgImageWidth;
    cfg_if.data    = '0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    width_reg      = rtbp_pkg::ResetWidth;
    height_reg     = rtbp_pkg::ResetHeight;
    thr_reg        = rtbp_pkg::ResetThreshold;
    col_count      = 0;
    row_count      = 0;
    partial_bits   = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    rst_n          = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_row();
    test_threshold_extremes();
    test_size_extremes();
    test_mid_image_write();
    test_random_images(0, 0);
    test_random_images(62, 0);
    test_random_images(0, 62);
    test_random_images(9, 9);

    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
